>>> src/page_framebuffer_text_and_bar_renderer_macros.svh
// Assertion macros used by the checker file of the renderer.
`ifndef PAGE_FRAMEBUFFER_TEXT_AND_BAR_RENDERER_MACROS_SVH
`define PAGE_FRAMEBUFFER_TEXT_AND_BAR_RENDERER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PFBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PFBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pfbr_pkg.sv
// Shared types, constants and the 5x7 glyph table of the framebuffer renderer.
package pfbr_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ORIGIN = 3'd1,
    OP_CHAR   = 3'd2,
    OP_BAR    = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CHAR,
    ST_MUL1,
    ST_MUL2,
    ST_BAR,
    ST_RD,
    ST_WR,
    ST_READ,
    ST_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic set_origin;
    logic sweep;
    logic char_setup;
    logic bar_mul1;
    logic bar_mul2;
    logic bar_setup;
    logic walk_rd;
    logic walk_wr;
    logic idx_rd;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sweep_last;
    logic walk_empty;
    logic walk_last;
    logic out_free;
  } sts_t;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_FIRST   = 8'd32;
  localparam logic [7:0] CHAR_LAST    = 8'd126;
  localparam int         CHAR_ADVANCE = 6;
  localparam int         LINE_STEP    = 8;
  localparam int         CURSOR_MAX   = 2047;
  localparam int         GLYPH_COLS   = 5;
  localparam int         GLYPH_ROWS   = 7;
  localparam int         PERCENT      = 100;
  // floor(n/100) == (n*FILL_RECIP) >> FILL_SHIFT for n < 2^16
  localparam int         FILL_SHIFT   = 23;
  localparam int         FILL_RECIP   = ((1 << FILL_SHIFT) + PERCENT - 1) / PERCENT;

  // Column bytes of a glyph, column 0 in the low byte. Blank past 'Z'.
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'd33: g = 40'h00005f0000;
      8'd34: g = 40'h0007000700;
      8'd35: g = 40'h147f147f14;
      8'd36: g = 40'h122a7f2a24;
      8'd37: g = 40'h6264081323;
      8'd38: g = 40'h5022554936;
      8'd39: g = 40'h0000030500;
      8'd40: g = 40'h0041221c00;
      8'd41: g = 40'h001c224100;
      8'd42: g = 40'h082a1c2a08;
      8'd43: g = 40'h08083e0808;
      8'd44: g = 40'h0000305000;
      8'd45: g = 40'h0808080808;
      8'd46: g = 40'h0000606000;
      8'd47: g = 40'h0204081020;
      8'd48: g = 40'h3e4549513e;
      8'd49: g = 40'h00407f4200;
      8'd50: g = 40'h4649516142;
      8'd51: g = 40'h314b454121;
      8'd52: g = 40'h107f121418;
      8'd53: g = 40'h3945454527;
      8'd54: g = 40'h3049494a3c;
      8'd55: g = 40'h0305097101;
      8'd56: g = 40'h3649494936;
      8'd57: g = 40'h1e29494906;
      8'd58: g = 40'h0000363600;
      8'd59: g = 40'h0000365600;
      8'd60: g = 40'h4122140800;
      8'd61: g = 40'h1414141414;
      8'd62: g = 40'h0008142241;
      8'd63: g = 40'h0609510100;
      8'd64: g = 40'h3e41794932;
      8'd65: g = 40'h7e1111117e;
      8'd66: g = 40'h364949497f;
      8'd67: g = 40'h224141413e;
      8'd68: g = 40'h1c2241417f;
      8'd69: g = 40'h414949497f;
      8'd70: g = 40'h010109097f;
      8'd71: g = 40'h325141413e;
      8'd72: g = 40'h7f0808087f;
      8'd73: g = 40'h00417f4100;
      8'd74: g = 40'h013f414020;
      8'd75: g = 40'h412214087f;
      8'd76: g = 40'h404040407f;
      8'd77: g = 40'h7f0204027f;
      8'd78: g = 40'h7f1008047f;
      8'd79: g = 40'h3e4141413e;
      8'd80: g = 40'h060909097f;
      8'd81: g = 40'h5e2151413e;
      8'd82: g = 40'h462919097f;
      8'd83: g = 40'h3149494946;
      8'd84: g = 40'h01017f0101;
      8'd85: g = 40'h3f4040403f;
      8'd86: g = 40'h1f2040201f;
      8'd87: g = 40'h7f2018207f;
      8'd88: g = 40'h6314081463;
      8'd89: g = 40'h0304780403;
      8'd90: g = 40'h4345495161;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

endpackage

>>> src/page_framebuffer_text_and_bar_renderer.sv
// Top level of the page-ordered framebuffer renderer (text and progress bar).
// Use: one command beat enters on the input channel (in_valid_i / in_stall_o),
//   one result beat leaves on the output channel (out_valid_o / out_stall_i).
//   A beat is taken at a clock edge with valid high and stall low.
// Commands: clear, set text origin, draw character, draw progress bar, read byte.
//   Every command returns exactly one result; only a read carries data.
// Work per command: origin and unused codes go straight to the result; read
//   fetches one byte; clear sweeps the whole frame memory to zero; character
//   and bar read-modify-write each touched byte (a character touches at most
//   5 columns x 2 pages), a bar after working out its fill (a multiply, then
//   a scaled reciprocal multiply for the /100). When nothing is drawn, no walk.
// Rate is set by the frame memory: every drawn byte is a read-modify-write
//   in a read state and a write state, and one command is worked at a time.
// Reset: the frame memory is swept to zero, one byte a cycle, over all
//   DISPLAY_WIDTH*DISPLAY_HEIGHT/8 bytes; in_stall_o stays high meanwhile.
// A stalled result waits in the output register; the next command is still
//   accepted and worked, and only its own result waits for the register.
module page_framebuffer_text_and_bar_renderer #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        operation_i,
  input  logic signed [8:0] x_pos_i,
  input  logic signed [8:0] y_pos_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        bar_width_i,
  input  logic [7:0]        bar_height_i,
  input  logic [7:0]        progress_i,
  input  logic [9:0]        read_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic              index_error_o
);

  pfbr_pkg::cmd_t cmd;
  pfbr_pkg::sts_t sts;

  // sequencing: accept, sweep, walk, result handoff
  pfbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // memory, cursor, byte masks and result register
  pfbr_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .char_code_i   (char_code_i),
    .bar_width_i   (bar_width_i),
    .bar_height_i  (bar_height_i),
    .progress_i    (progress_i),
    .read_index_i  (read_index_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .read_data_o   (read_data_o),
    .index_error_o (index_error_o)
  );

endmodule

>>> src/pfbr_ctrl.sv
// Controller state machine of the framebuffer renderer.
module pfbr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      operation_i,
  output logic            in_stall_o,
  output pfbr_pkg::cmd_t  cmd_o,
  input  pfbr_pkg::sts_t  sts_i
);

  pfbr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfbr_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pfbr_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = pfbr_pkg::ST_IDLE;
      end
      pfbr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (operation_i)
            pfbr_pkg::OP_CLEAR: state_d = pfbr_pkg::ST_CLEAR;
            pfbr_pkg::OP_ORIGIN: begin
              cmd_o.set_origin = 1'b1;
              state_d = pfbr_pkg::ST_DONE;
            end
            pfbr_pkg::OP_CHAR: state_d = pfbr_pkg::ST_CHAR;
            pfbr_pkg::OP_BAR:  state_d = pfbr_pkg::ST_MUL1;
            pfbr_pkg::OP_READ: state_d = pfbr_pkg::ST_READ;
            default:           state_d = pfbr_pkg::ST_DONE;
          endcase
        end
      end
      pfbr_pkg::ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = pfbr_pkg::ST_DONE;
      end
      pfbr_pkg::ST_CHAR: begin
        cmd_o.char_setup = 1'b1;
        state_d = pfbr_pkg::ST_RD;
      end
      pfbr_pkg::ST_MUL1: begin
        cmd_o.bar_mul1 = 1'b1;
        state_d = pfbr_pkg::ST_MUL2;
      end
      pfbr_pkg::ST_MUL2: begin
        cmd_o.bar_mul2 = 1'b1;
        state_d = pfbr_pkg::ST_BAR;
      end
      pfbr_pkg::ST_BAR: begin
        cmd_o.bar_setup = 1'b1;
        state_d = pfbr_pkg::ST_RD;
      end
      pfbr_pkg::ST_RD: begin
        if (sts_i.walk_empty) begin
          state_d = pfbr_pkg::ST_DONE;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d = pfbr_pkg::ST_WR;
        end
      end
      pfbr_pkg::ST_WR: begin
        cmd_o.walk_wr = 1'b1;
        state_d = sts_i.walk_last ? pfbr_pkg::ST_DONE : pfbr_pkg::ST_RD;
      end
      pfbr_pkg::ST_READ: begin
        cmd_o.idx_rd = 1'b1;
        state_d = pfbr_pkg::ST_DONE;
      end
      pfbr_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = pfbr_pkg::ST_IDLE;
        end
      end
      default: state_d = pfbr_pkg::ST_INIT;
    endcase
  end

endmodule

>>> src/pfbr_datapath.sv
// Datapath: frame memory, cursor, byte walker, bar fill arithmetic and result register.
module pfbr_datapath #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfbr_pkg::cmd_t     cmd_i,
  output pfbr_pkg::sts_t     sts_o,
  input  logic [2:0]         operation_i,
  input  logic signed [8:0]  x_pos_i,
  input  logic signed [8:0]  y_pos_i,
  input  logic [7:0]         char_code_i,
  input  logic [7:0]         bar_width_i,
  input  logic [7:0]         bar_height_i,
  input  logic [7:0]         progress_i,
  input  logic [9:0]         read_index_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         read_data_o,
  output logic               index_error_o
);

  localparam int NP = DISPLAY_HEIGHT / 8;
  localparam int NB = DISPLAY_WIDTH * NP;
  localparam int AW = $clog2(NB);
  localparam int CW = $clog2(DISPLAY_WIDTH);
  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam logic signed [13:0] WMAX = 14'(DISPLAY_WIDTH - 1);
  localparam logic signed [13:0] PMAX = 14'(NP - 1);
  localparam logic signed [13:0] CMAX = 14'(pfbr_pkg::CURSOR_MAX);

  // captured command
  logic [2:0]        op_q;
  logic signed [8:0] x_q, y_q;
  logic [7:0]        code_q, w_q, h_q, p_q;
  logic [9:0]        idx_q;

  // text state
  logic signed [8:0]  ox_q;
  logic signed [11:0] cx_q, cy_q;

  // walker
  logic [CW-1:0]      col_q, col_lo_q, col_hi_q;
  logic [PW-1:0]      pg_q, pg_lo_q, pg_hi_q;
  logic               empty_q, bar_mode_q;
  logic signed [13:0] gx_q, gy_q;

  logic [15:0]  prod_q;
  logic [9:0]   fill_q;
  logic [32:0]  fprod;
  logic [AW-1:0] sweep_q;
  logic         sweep_last;

  logic [7:0]   mem [NB];
  logic [7:0]   rdata_q;
  logic         mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr, walk_addr;
  logic [7:0]   mem_wdata;

  logic         out_valid_q, index_error_q;
  logic [7:0]   read_data_q;
  logic         idx_bad;

  // setup terms
  logic signed [13:0] su_xs, su_xe, su_ys, su_ye, su_ys3, su_ye3, su_imax, su_wm1;
  logic signed [13:0] cx14, cy14, cx_adv, cy_adv;
  logic               su_skip, su_empty, drawable;
  logic [7:0]         nbar;

  // mask terms
  logic signed [13:0] iv, pg14, jb, wv, hv, fv;
  logic signed [13:0] jrow [8];
  logic [39:0]        glyph;
  logic [6:0]         gcol;
  logic [14:0]        gsh;
  logic [7:0]         char_mask, bar_mask, mask;
  logic               col_c, col_b;

  assign cx14     = {{2{cx_q[11]}}, cx_q};
  assign cy14     = {{2{cy_q[11]}}, cy_q};
  assign cx_adv   = cx14 + 14'(pfbr_pkg::CHAR_ADVANCE);
  assign cy_adv   = cy14 + 14'(pfbr_pkg::LINE_STEP);
  assign drawable = (code_q >= pfbr_pkg::CHAR_FIRST) && (code_q <= pfbr_pkg::CHAR_LAST);
  assign nbar     = (w_q >= 8'd2) ? (w_q - 8'd2) : 8'd0;
  assign fprod    = 33'(prod_q) * 33'(pfbr_pkg::FILL_RECIP);
  assign su_wm1   = {6'd0, w_q} - 14'sd1;

  always_comb begin
    if (cmd_i.bar_setup) begin
      su_imax = ($signed({4'd0, fill_q}) > su_wm1) ? $signed({4'd0, fill_q}) : su_wm1;
      su_xs   = {{5{x_q[8]}}, x_q};
      su_ys   = {{5{y_q[8]}}, y_q};
      su_xe   = su_xs + su_imax;
      su_ye   = su_ys + $signed({6'd0, h_q}) - 14'sd1;
      su_skip = (h_q == 8'd0) || (su_imax < 0);
    end else begin
      su_imax = '0;
      su_xs   = cx14;
      su_ys   = cy14;
      su_xe   = cx14 + 14'(pfbr_pkg::GLYPH_COLS - 1);
      su_ye   = cy14 + 14'(pfbr_pkg::GLYPH_ROWS - 1);
      su_skip = !drawable;
    end
    su_ys3   = su_ys >>> 3;
    su_ye3   = su_ye >>> 3;
    su_empty = su_skip || (su_xe < 0) || (su_xs > WMAX) || (su_ye < 0) || (su_ys3 > PMAX);
  end

  // per-byte OR mask for the walker position
  always_comb begin
    iv    = $signed({{(14-CW){1'b0}}, col_q}) - gx_q;
    pg14  = $signed({{(14-PW){1'b0}}, pg_q});
    jb    = pg14 * 14'sd8 - gy_q;
    glyph = pfbr_pkg::glyph_bits(code_q);
    case (iv[2:0])
      3'd0:    gcol = glyph[6:0];
      3'd1:    gcol = glyph[14:8];
      3'd2:    gcol = glyph[22:16];
      3'd3:    gcol = glyph[30:24];
      3'd4:    gcol = glyph[38:32];
      default: gcol = 7'd0;
    endcase
    gsh       = {8'd0, gcol} << gy_q[2:0];
    char_mask = (pg14 != (gy_q >>> 3)) ? {1'b0, gsh[14:8]} : gsh[7:0];
    wv    = $signed({6'd0, w_q});
    hv    = $signed({6'd0, h_q});
    fv    = $signed({4'd0, fill_q});
    col_c = iv >= wv;
    col_b = (iv == 0) || (iv == wv - 14'sd1) || (iv <= fv);
    for (int b = 0; b < 8; b++) begin
      jrow[b] = jb + 14'(b);
      if (col_c) begin
        bar_mask[b] = (jrow[b] >= 14'sd1) && (jrow[b] <= hv - 14'sd2);
      end else if (col_b) begin
        bar_mask[b] = (jrow[b] >= 14'sd0) && (jrow[b] <= hv - 14'sd1);
      end else begin
        bar_mask[b] = (jrow[b] == 14'sd0) || (jrow[b] == hv - 14'sd1);
      end
    end
    mask = bar_mode_q ? bar_mask : char_mask;
  end

  assign walk_addr  = AW'(pg_q * DISPLAY_WIDTH) + AW'(col_q);
  assign sweep_last = sweep_q == AW'(NB - 1);
  assign idx_bad    = {22'd0, idx_q} >= 32'(NB);

  assign mem_we    = cmd_i.sweep || cmd_i.walk_wr;
  assign mem_waddr = cmd_i.sweep ? sweep_q : walk_addr;
  assign mem_wdata = cmd_i.sweep ? 8'd0 : (rdata_q | mask);
  assign mem_re    = cmd_i.walk_rd || cmd_i.idx_rd;
  assign mem_raddr = cmd_i.idx_rd ? AW'(idx_q) : walk_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      x_q    <= x_pos_i;
      y_q    <= y_pos_i;
      code_q <= char_code_i;
      w_q    <= bar_width_i;
      h_q    <= bar_height_i;
      p_q    <= progress_i;
      idx_q  <= read_index_i;
    end
    if (cmd_i.bar_mul1) prod_q <= {8'd0, nbar} * {8'd0, p_q};
    if (cmd_i.bar_mul2) fill_q <= 10'(fprod >> pfbr_pkg::FILL_SHIFT);
    if (cmd_i.char_setup || cmd_i.bar_setup) begin
      bar_mode_q <= cmd_i.bar_setup;
      empty_q    <= su_empty;
      gx_q       <= su_xs;
      gy_q       <= su_ys;
      col_lo_q   <= (su_xs < 0) ? '0 : su_xs[CW-1:0];
      col_q      <= (su_xs < 0) ? '0 : su_xs[CW-1:0];
      col_hi_q   <= (su_xe > WMAX) ? WMAX[CW-1:0] : su_xe[CW-1:0];
      pg_lo_q    <= (su_ys3 < 0) ? '0 : su_ys3[PW-1:0];
      pg_q       <= (su_ys3 < 0) ? '0 : su_ys3[PW-1:0];
      pg_hi_q    <= (su_ye3 > PMAX) ? PMAX[PW-1:0] : su_ye3[PW-1:0];
    end else if (cmd_i.walk_wr) begin
      if (pg_q == pg_hi_q) begin
        pg_q  <= pg_lo_q;
        col_q <= col_q + 1'b1;
      end else begin
        pg_q <= pg_q + 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      read_data_q   <= (op_q == pfbr_pkg::OP_READ && !idx_bad) ? rdata_q : 8'd0;
      index_error_q <= (op_q == pfbr_pkg::OP_READ) && idx_bad;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      ox_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
    end else begin
      if (cmd_i.sweep) sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.set_origin) begin
        ox_q <= x_pos_i;
        cx_q <= {{3{x_pos_i[8]}}, x_pos_i};
        cy_q <= {{3{y_pos_i[8]}}, y_pos_i};
      end else if (cmd_i.char_setup) begin
        if (code_q == pfbr_pkg::CHAR_NEWLINE) begin
          cx_q <= {{3{ox_q[8]}}, ox_q};
          cy_q <= (cy_adv > CMAX) ? CMAX[11:0] : cy_adv[11:0];
        end else if (drawable) begin
          cx_q <= (cx_adv > CMAX) ? CMAX[11:0] : cx_adv[11:0];
        end
      end
    end
  end

  assign sts_o.sweep_last = sweep_last;
  assign sts_o.walk_empty = empty_q;
  assign sts_o.walk_last  = (pg_q == pg_hi_q) && (col_q == col_hi_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign index_error_o = index_error_q;

endmodule

>>> src/pfbr_checker.sv
// Port-level checker of the renderer and its bind to the top level.
`include "page_framebuffer_text_and_bar_renderer_macros.svh"

module pfbr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic       index_error_o
);

  `PFBR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(read_data_o) && $stable(index_error_o), "stalled result beat changed")
  `PFBR_ASSERT_NOW(a_err_no_data, out_valid_o && index_error_o, read_data_o == 8'd0, "index error with nonzero data")
  `PFBR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "command accepted while busy")

endmodule

bind page_framebuffer_text_and_bar_renderer pfbr_checker u_pfbr_checker (.*);
